>>> rtl/gotb_pkg.sv
// Shared types, widths and helpers for the glyph outline to Bezier path converter.
package gotb_pkg;

  // Coordinate and fixed-point geometry.
  localparam int COORD_W    = 16;
  localparam int FRAC_BITS  = 16;
  localparam int INT_BITS   = 24;
  localparam int SCALE_W    = 24;
  localparam int OFFSET_W   = 32;
  localparam int OUT_W      = INT_BITS + FRAC_BITS;
  localparam int PROD_W     = COORD_W + SCALE_W;
  localparam int SUM_W      = ((PROD_W > OFFSET_W) ? PROD_W : OFFSET_W) + 2;
  localparam int SAT_W      = (SUM_W > OUT_W) ? SUM_W : OUT_W;
  localparam int SCALE_ONE  = 65536;

  // Divide-by-three datapath: |d| = hi * 2^SPLIT + lo,
  // |d| / 3 = hi * K1 + (R1 * hi + lo) / 3, the last term by reciprocal.
  localparam int DIFF_W     = OUT_W + 1;
  localparam int DIV_SPLIT  = (DIFF_W + 1) / 2;
  localparam int DIV_HI_W   = DIFF_W - DIV_SPLIT;
  localparam int DIV_K1     = (1 << DIV_SPLIT) / 3;
  localparam int DIV_R1     = (1 << DIV_SPLIT) % 3;
  localparam int DIV_V_W    = DIV_SPLIT + 2;
  localparam int DIV_SH     = DIV_V_W + 1;
  localparam int DIV_K2     = ((1 << DIV_SH) + 2) / 3;
  localparam int DIV_VK_W   = DIV_V_W + DIV_SH - 1;
  localparam int DIV_VQ_W   = DIV_V_W - 1;

  // Point slots of one event and divider lanes.
  localparam int N_PTS      = 3;
  localparam int PT_C1      = 0;
  localparam int PT_C2      = 1;
  localparam int PT_END     = 2;
  localparam int N_DIV      = 4;
  localparam int DV_C1X     = 0;
  localparam int DV_C1Y     = 1;
  localparam int DV_C2X     = 2;
  localparam int DV_C2Y     = 3;

  // Ports and queue.
  localparam int MODE_W     = 3;
  localparam int CODE_W     = 2;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;
  localparam int FIFO_PTR_W = 2;
  localparam int FIFO_DEPTH = 1 << FIFO_PTR_W;
  localparam int FIFO_CNT_W = FIFO_PTR_W + 1;

  typedef enum logic [MODE_W-1:0] {
    MODE_MOVE,
    MODE_LINE,
    MODE_CONIC,
    MODE_CUBIC,
    MODE_END
  } mode_e;

  typedef enum logic [CODE_W-1:0] {
    CODE_MOVETO,
    CODE_LINETO,
    CODE_CURVETO,
    CODE_END
  } code_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SCALE_XX,
    CFG_SHEAR_XY,
    CFG_SHEAR_YX,
    CFG_SCALE_YY,
    CFG_OFFSET_X,
    CFG_OFFSET_Y
  } cfg_idx_e;

  typedef struct packed {
    logic signed [SCALE_W-1:0]  scale_xx;
    logic signed [SCALE_W-1:0]  shear_xy;
    logic signed [SCALE_W-1:0]  shear_yx;
    logic signed [SCALE_W-1:0]  scale_yy;
    logic signed [OFFSET_W-1:0] offset_x;
    logic signed [OFFSET_W-1:0] offset_y;
  } cfg_t;

  typedef struct packed {
    logic signed [OUT_W-1:0] x;
    logic signed [OUT_W-1:0] y;
  } point_t;

  // One path element as it travels from the front end to the back end.
  typedef struct packed {
    code_e  code;
    logic   same_end;
    point_t c1;
    point_t c2;
    point_t e;
  } elem_t;

  function automatic logic signed [OUT_W-1:0] sat_out(input logic signed [SUM_W-1:0] v);
    logic signed [SAT_W-1:0] w;
    logic signed [SAT_W-1:0] hi;
    logic signed [SAT_W-1:0] lo;
    w  = SAT_W'(v);
    hi = SAT_W'($signed({1'b0, {(OUT_W-1){1'b1}}}));
    lo = SAT_W'($signed({1'b1, {(OUT_W-1){1'b0}}}));
    if (w > hi) begin
      return hi[OUT_W-1:0];
    end else if (w < lo) begin
      return lo[OUT_W-1:0];
    end
    return w[OUT_W-1:0];
  endfunction

  function automatic logic signed [OUT_W-1:0] map_sum(input logic signed [PROD_W-1:0] a,
                                                      input logic signed [PROD_W-1:0] b,
                                                      input logic signed [OFFSET_W-1:0] off);
    logic signed [SUM_W-1:0] s;
    s = SUM_W'(a) + SUM_W'(b) + SUM_W'(off);
    return sat_out(s);
  endfunction

endpackage

>>> rtl/gotb_front.sv
// Front end: configuration registers, event intake, affine map and conic-to-cubic math.
module gotb_front (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   cfg_valid_i,
  input  logic [gotb_pkg::CFG_IDX_W-1:0]         cfg_index_i,
  input  logic [gotb_pkg::CFG_DATA_W-1:0]        cfg_data_i,
  input  logic                                   in_valid_i,
  output logic                                   in_ready_o,
  input  logic [gotb_pkg::MODE_W-1:0]            mode_i,
  input  logic signed [gotb_pkg::COORD_W-1:0]    ctrl1_x_i,
  input  logic signed [gotb_pkg::COORD_W-1:0]    ctrl1_y_i,
  input  logic signed [gotb_pkg::COORD_W-1:0]    ctrl2_x_i,
  input  logic signed [gotb_pkg::COORD_W-1:0]    ctrl2_y_i,
  input  logic signed [gotb_pkg::COORD_W-1:0]    end_x_i,
  input  logic signed [gotb_pkg::COORD_W-1:0]    end_y_i,
  output logic                                   elem_valid_o,
  input  logic                                   elem_ready_i,
  output gotb_pkg::elem_t                        elem_o
);
  import gotb_pkg::*;

  typedef struct packed {
    logic signed [PROD_W-1:0] xx;
    logic signed [PROD_W-1:0] yx;
    logic signed [PROD_W-1:0] xy;
    logic signed [PROD_W-1:0] yy;
  } prods_t;

  typedef struct packed {
    logic [MODE_W-1:0]        mode;
    logic                     same;
    point_t [N_PTS-1:0]       pt;
  } ctx_t;

  function automatic prods_t mul_pt(input logic signed [COORD_W-1:0] x,
                                    input logic signed [COORD_W-1:0] y,
                                    input cfg_t c);
    prods_t p;
    logic signed [PROD_W-1:0] xw;
    logic signed [PROD_W-1:0] yw;
    xw   = PROD_W'(x);
    yw   = PROD_W'(y);
    p.xx = xw * PROD_W'($signed(c.scale_xx));
    p.yx = yw * PROD_W'($signed(c.shear_yx));
    p.xy = xw * PROD_W'($signed(c.shear_xy));
    p.yy = yw * PROD_W'($signed(c.scale_yy));
    return p;
  endfunction

  cfg_t cfg_q, cfg_d;

  logic adv;

  logic signed [COORD_W-1:0] raw_x [N_PTS];
  logic signed [COORD_W-1:0] raw_y [N_PTS];

  logic              s1_valid_q, s1_valid_d;
  logic [MODE_W-1:0] s1_mode_q;
  prods_t            s1_prod_q [N_PTS];
  prods_t            s1_prod_d [N_PTS];

  logic s2_valid_q, s3_valid_q, s4_valid_q, s5_valid_q;
  ctx_t s2_ctx_q, s2_ctx_d;
  ctx_t s3_ctx_q, s3_ctx_d;
  ctx_t s4_ctx_q, s5_ctx_q;

  point_t last_q, last_d;

  logic signed [DIFF_W-1:0] s3_diff_q [N_DIV];
  logic signed [DIFF_W-1:0] s3_diff_d [N_DIV];
  logic [N_DIV-1:0]         s4_neg_q, s4_neg_d, s5_neg_q;
  logic [DIFF_W-1:0]        s4_mag_q [N_DIV];
  logic [DIFF_W-1:0]        s4_mag_d [N_DIV];
  logic [DIFF_W-1:0]        s5_hik_q [N_DIV];
  logic [DIFF_W-1:0]        s5_hik_d [N_DIV];
  logic [DIV_VQ_W-1:0]      s5_vq_q  [N_DIV];
  logic [DIV_VQ_W-1:0]      s5_vq_d  [N_DIV];

  // Configuration registers.
  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      case (cfg_index_i)
        CFG_SCALE_XX: cfg_d.scale_xx = cfg_data_i[SCALE_W-1:0];
        CFG_SHEAR_XY: cfg_d.shear_xy = cfg_data_i[SCALE_W-1:0];
        CFG_SHEAR_YX: cfg_d.shear_yx = cfg_data_i[SCALE_W-1:0];
        CFG_SCALE_YY: cfg_d.scale_yy = cfg_data_i[SCALE_W-1:0];
        CFG_OFFSET_X: cfg_d.offset_x = cfg_data_i[OFFSET_W-1:0];
        CFG_OFFSET_Y: cfg_d.offset_y = cfg_data_i[OFFSET_W-1:0];
        default:      cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.scale_xx <= SCALE_W'(SCALE_ONE);
      cfg_q.shear_xy <= '0;
      cfg_q.shear_yx <= '0;
      cfg_q.scale_yy <= SCALE_W'(SCALE_ONE);
      cfg_q.offset_x <= '0;
      cfg_q.offset_y <= '0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  // The whole front pipe moves together whenever its last stage can drain.
  assign adv        = !s5_valid_q || elem_ready_i;
  assign in_ready_o = adv;

  assign raw_x[PT_C1]  = ctrl1_x_i;
  assign raw_y[PT_C1]  = ctrl1_y_i;
  assign raw_x[PT_C2]  = ctrl2_x_i;
  assign raw_y[PT_C2]  = ctrl2_y_i;
  assign raw_x[PT_END] = end_x_i;
  assign raw_y[PT_END] = end_y_i;

  // Stage 1: undefined modes are swallowed here; products of every point.
  assign s1_valid_d = in_valid_i && (mode_i <= MODE_END);

  always_comb begin
    for (int i = 0; i < N_PTS; i++) begin
      s1_prod_d[i] = mul_pt(raw_x[i], raw_y[i], cfg_q);
    end
  end

  // Stage 2: sums with offset and saturation.
  always_comb begin
    s2_ctx_d      = '0;
    s2_ctx_d.mode = s1_mode_q;
    for (int i = 0; i < N_PTS; i++) begin
      s2_ctx_d.pt[i].x = map_sum(s1_prod_q[i].xx, s1_prod_q[i].yx, cfg_q.offset_x);
      s2_ctx_d.pt[i].y = map_sum(s1_prod_q[i].xy, s1_prod_q[i].yy, cfg_q.offset_y);
    end
  end

  // Stage 3: compare against and difference from the previous end point.
  // Dropped moves and lines always repeat that point, so it simply follows
  // the end point of every point-carrying event in order.
  always_comb begin
    s3_ctx_d      = s2_ctx_q;
    s3_ctx_d.same = (s2_ctx_q.pt[PT_END] == last_q);
    s3_diff_d[DV_C1X] = DIFF_W'(s2_ctx_q.pt[PT_C1].x) - DIFF_W'(last_q.x);
    s3_diff_d[DV_C1Y] = DIFF_W'(s2_ctx_q.pt[PT_C1].y) - DIFF_W'(last_q.y);
    s3_diff_d[DV_C2X] = DIFF_W'(s2_ctx_q.pt[PT_END].x) - DIFF_W'(s2_ctx_q.pt[PT_C1].x);
    s3_diff_d[DV_C2Y] = DIFF_W'(s2_ctx_q.pt[PT_END].y) - DIFF_W'(s2_ctx_q.pt[PT_C1].y);
    last_d = last_q;
    if (adv && s2_valid_q && (s2_ctx_q.mode != MODE_END)) begin
      last_d = s2_ctx_q.pt[PT_END];
    end
  end

  // Stage 4: sign and magnitude of each difference.
  always_comb begin
    for (int k = 0; k < N_DIV; k++) begin
      s4_neg_d[k] = s3_diff_q[k][DIFF_W-1];
      s4_mag_d[k] = s4_neg_d[k] ? DIFF_W'(-s3_diff_q[k]) : DIFF_W'(s3_diff_q[k]);
    end
  end

  // Stage 5: magnitude divided by three in two partial terms.
  always_comb begin
    logic [DIV_HI_W-1:0]  hi;
    logic [DIV_SPLIT-1:0] lo;
    logic [DIV_V_W-1:0]   v;
    logic [DIV_VK_W-1:0]  vk;
    for (int k = 0; k < N_DIV; k++) begin
      hi          = s4_mag_q[k][DIFF_W-1:DIV_SPLIT];
      lo          = s4_mag_q[k][DIV_SPLIT-1:0];
      s5_hik_d[k] = DIFF_W'(hi) * DIFF_W'(DIV_K1);
      v           = DIV_V_W'(hi) * DIV_V_W'(DIV_R1) + DIV_V_W'(lo);
      vk          = DIV_VK_W'(v) * DIV_VK_W'(DIV_K2);
      s5_vq_d[k]  = vk[DIV_VK_W-1:DIV_SH];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s2_valid_q <= 1'b0;
      s3_valid_q <= 1'b0;
      s4_valid_q <= 1'b0;
      s5_valid_q <= 1'b0;
      last_q     <= '0;
    end else begin
      last_q <= last_d;
      if (adv) begin
        s1_valid_q <= s1_valid_d;
        s2_valid_q <= s1_valid_q;
        s3_valid_q <= s2_valid_q;
        s4_valid_q <= s3_valid_q;
        s5_valid_q <= s4_valid_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s1_mode_q <= mode_i;
      s1_prod_q <= s1_prod_d;
      s2_ctx_q  <= s2_ctx_d;
      s3_ctx_q  <= s3_ctx_d;
      s3_diff_q <= s3_diff_d;
      s4_ctx_q  <= s3_ctx_q;
      s4_neg_q  <= s4_neg_d;
      s4_mag_q  <= s4_mag_d;
      s5_ctx_q  <= s4_ctx_q;
      s5_neg_q  <= s4_neg_q;
      s5_hik_q  <= s5_hik_d;
      s5_vq_q   <= s5_vq_d;
    end
  end

  // Element assembly. Truncation toward zero is folded into the sign:
  // c1 = C - trunc((C - S) / 3), c2 = C + trunc((E - C) / 3).
  always_comb begin
    logic [OUT_W-1:0] q [N_DIV];
    point_t           c;
    for (int k = 0; k < N_DIV; k++) begin
      q[k] = OUT_W'(s5_hik_q[k] + DIFF_W'(s5_vq_q[k]));
    end
    c        = s5_ctx_q.pt[PT_C1];
    elem_o   = '0;
    elem_o.same_end = s5_ctx_q.same;
    elem_o.e        = s5_ctx_q.pt[PT_END];
    case (s5_ctx_q.mode)
      MODE_MOVE: elem_o.code = CODE_MOVETO;
      MODE_LINE: elem_o.code = CODE_LINETO;
      MODE_CONIC: begin
        elem_o.code = CODE_CURVETO;
        elem_o.c1.x = s5_neg_q[DV_C1X] ? c.x + q[DV_C1X] : c.x - q[DV_C1X];
        elem_o.c1.y = s5_neg_q[DV_C1Y] ? c.y + q[DV_C1Y] : c.y - q[DV_C1Y];
        elem_o.c2.x = s5_neg_q[DV_C2X] ? c.x - q[DV_C2X] : c.x + q[DV_C2X];
        elem_o.c2.y = s5_neg_q[DV_C2Y] ? c.y - q[DV_C2Y] : c.y + q[DV_C2Y];
      end
      MODE_CUBIC: begin
        elem_o.code = CODE_CURVETO;
        elem_o.c1   = s5_ctx_q.pt[PT_C1];
        elem_o.c2   = s5_ctx_q.pt[PT_C2];
      end
      default: begin
        elem_o.code = CODE_END;
        elem_o.e    = '0;
      end
    endcase
  end

  assign elem_valid_o = s5_valid_q;

endmodule

>>> rtl/gotb_fifo.sv
// Short element queue between the front end and the back end.
module gotb_fifo (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_valid_i,
  output logic            push_ready_o,
  input  gotb_pkg::elem_t push_data_i,
  output logic            pop_valid_o,
  input  logic            pop_ready_i,
  output gotb_pkg::elem_t pop_data_o
);
  import gotb_pkg::*;

  elem_t                 mem_q [FIFO_DEPTH];
  logic [FIFO_PTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [FIFO_PTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [FIFO_CNT_W-1:0] cnt_q, cnt_d;
  logic                  push, pop;

  assign push_ready_o = (cnt_q != FIFO_CNT_W'(FIFO_DEPTH));
  assign pop_valid_o  = (cnt_q != '0);
  assign pop_data_o   = mem_q[rd_ptr_q];
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;

  always_comb begin
    wr_ptr_d = push ? wr_ptr_q + 1'b1 : wr_ptr_q;
    rd_ptr_d = pop ? rd_ptr_q + 1'b1 : rd_ptr_q;
    cnt_d    = cnt_q;
    if (push && !pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop && !push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

>>> rtl/gotb_back.sv
// Back end: drop rules for repeated points, outline state and the output register.
module gotb_back (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            elem_valid_i,
  output logic            elem_ready_o,
  input  gotb_pkg::elem_t elem_i,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  output gotb_pkg::elem_t out_elem_o
);
  import gotb_pkg::*;

  logic  out_valid_q, out_valid_d;
  elem_t out_elem_q;
  logic  has_q, has_d;
  logic  take, pop, emit;

  assign take         = !out_valid_q || out_ready_i;
  assign elem_ready_o = take;
  assign pop          = elem_valid_i && take;

  always_comb begin
    case (elem_i.code)
      CODE_MOVETO: emit = !(has_q && elem_i.same_end);
      CODE_LINETO: emit = !elem_i.same_end;
      default:     emit = 1'b1;
    endcase
    out_valid_d = out_valid_q;
    has_d       = has_q;
    if (take) begin
      out_valid_d = pop && emit;
    end
    if (pop && emit) begin
      has_d = (elem_i.code != CODE_END);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      has_q       <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
      has_q       <= has_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop && emit) begin
      out_elem_q <= elem_i;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_elem_o  = out_elem_q;

endmodule

>>> rtl/glyph_outline_to_bezier_path.sv
// Top level of the glyph outline to Bezier path converter.
//
//   Channel  Direction  Handshake               Beat contents
//   cfg      in         cfg_valid_i/cfg_ready_o cfg_index_i, cfg_data_i
//   in       in         in_valid_i/in_ready_o   mode_i, ctrl1/ctrl2/end points
//   out      out        out_valid_o/out_ready_i code_o, out_c1/out_c2/out_end points
//
// One outline event is taken per cycle when the output side keeps up.
// An accepted event is loaded by the edge that takes it into the first of five
// front stages (products, sums with saturation, comparison with the last end
// point, sign and magnitude, divide-by-three partial terms), and the queue
// entry and the output register follow.
// Reset restores the identity transform, clears the last end point and the
// outline flag, and empties the queue. Configuration beats are always taken.
// A stall at the output fills the output register, then the four-entry queue,
// and only then holds the front stages and drops in_ready_o.
module glyph_outline_to_bezier_path (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [gotb_pkg::CFG_IDX_W-1:0]      cfg_index_i,
  input  logic [gotb_pkg::CFG_DATA_W-1:0]     cfg_data_i,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  logic [gotb_pkg::MODE_W-1:0]         mode_i,
  input  logic signed [gotb_pkg::COORD_W-1:0] ctrl1_x_i,
  input  logic signed [gotb_pkg::COORD_W-1:0] ctrl1_y_i,
  input  logic signed [gotb_pkg::COORD_W-1:0] ctrl2_x_i,
  input  logic signed [gotb_pkg::COORD_W-1:0] ctrl2_y_i,
  input  logic signed [gotb_pkg::COORD_W-1:0] end_x_i,
  input  logic signed [gotb_pkg::COORD_W-1:0] end_y_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic [gotb_pkg::CODE_W-1:0]         code_o,
  output logic signed [gotb_pkg::OUT_W-1:0]   out_c1_x_o,
  output logic signed [gotb_pkg::OUT_W-1:0]   out_c1_y_o,
  output logic signed [gotb_pkg::OUT_W-1:0]   out_c2_x_o,
  output logic signed [gotb_pkg::OUT_W-1:0]   out_c2_y_o,
  output logic signed [gotb_pkg::OUT_W-1:0]   out_end_x_o,
  output logic signed [gotb_pkg::OUT_W-1:0]   out_end_y_o
);
  import gotb_pkg::*;

  // Front to queue.
  logic  fe_valid, fe_ready;
  elem_t fe_elem;

  // Queue to back end.
  logic  q_valid, q_ready;
  elem_t q_elem;

  elem_t out_elem;

  // The registers are plain flops, so a configuration beat never waits.
  assign cfg_ready_o = 1'b1;

  // The front end classifies each event, maps its points through the affine
  // transform and performs the conic-to-cubic raise. It tracks the previous
  // end point itself, since a dropped move or line always repeats it.
  gotb_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .mode_i       (mode_i),
    .ctrl1_x_i    (ctrl1_x_i),
    .ctrl1_y_i    (ctrl1_y_i),
    .ctrl2_x_i    (ctrl2_x_i),
    .ctrl2_y_i    (ctrl2_y_i),
    .end_x_i      (end_x_i),
    .end_y_i      (end_y_i),
    .elem_valid_o (fe_valid),
    .elem_ready_i (fe_ready),
    .elem_o       (fe_elem)
  );

  // The queue lets the front keep working while the output side stalls.
  gotb_fifo u_fifo (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (fe_valid),
    .push_ready_o (fe_ready),
    .push_data_i  (fe_elem),
    .pop_valid_o  (q_valid),
    .pop_ready_i  (q_ready),
    .pop_data_o   (q_elem)
  );

  // The back end applies the repeated-point drop rules, which depend on
  // whether the current outline has emitted anything yet, and holds the
  // result in the output register.
  gotb_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .elem_valid_i (q_valid),
    .elem_ready_o (q_ready),
    .elem_i       (q_elem),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .out_elem_o   (out_elem)
  );

  assign code_o      = out_elem.code;
  assign out_c1_x_o  = out_elem.c1.x;
  assign out_c1_y_o  = out_elem.c1.y;
  assign out_c2_x_o  = out_elem.c2.x;
  assign out_c2_y_o  = out_elem.c2.y;
  assign out_end_x_o = out_elem.e.x;
  assign out_end_y_o = out_elem.e.y;

endmodule
